/* sv/crc64sd_pkg.sv */
// ----------------------------------------------------------------------------
// crc64sd_pkg - shared types and constants
// Widths, reset polynomial and the bit-step operand type of the CRC divider.
// ----------------------------------------------------------------------------
package crc64sd_pkg;

	localparam int unsigned CRC_W  = 64;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned SEEN_W = 4;

	// bytes loaded without division before long division begins
	localparam logic [SEEN_W-1:0] FILL_BYTES = 4'd8;

	localparam logic [CRC_W-1:0] POLY_RESET = 64'h42F0_E1EB_A9EA_3693;

	typedef logic [CRC_W-1:0]  crc_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [SEEN_W-1:0] seen_t;

	// operands of one division step
	typedef struct packed {
		crc_t crc;
		crc_t poly;
		logic msg_bit;
	} step_in_t;

endpackage

/* sv/crc64sd_step.sv */
// ----------------------------------------------------------------------------
// crc64sd_step - one long-division bit step
// Shift left by one, bring the message bit into bit 0, and XOR in the
// polynomial when the bit leaving the top was set.
// ----------------------------------------------------------------------------
module crc64sd_step (
	input  crc64sd_pkg::step_in_t op,
	output crc64sd_pkg::crc_t     crc_next
);

	logic carry;

	assign carry = op.crc[crc64sd_pkg::CRC_W-1];

	always_comb begin
		crc_next = {op.crc[crc64sd_pkg::CRC_W-2:0], op.msg_bit};
		if (carry) begin
			crc_next = crc_next ^ op.poly;
		end
	end

endmodule

/* sv/crc64_shift_divider.sv */
// ----------------------------------------------------------------------------
// crc64_shift_divider - 64-bit CRC by bitwise MSB-first long division
// Configurable polynomial, one message byte per input transaction.
// ----------------------------------------------------------------------------
// Usage: send message bytes with s_tuser = 0 and s_tdata = byte, then one
// transaction with s_tuser = 1 to finalize; the CRC comes out on m_tdata and
// the register and byte count clear for the next message. The first eight
// bytes of a message load straight into the register, and the block stays
// ready for the next byte. Every later byte is divided in by eight steps of
// the single shared bit-step unit, and no new byte is taken until they are
// done. Finalize flushes 8 zero bits per byte received (at most 64 steps),
// then places the CRC in the output register, waiting while the previous
// CRC is still held there. Input and output are parted by the output
// register, so new bytes are taken while a CRC waits to be read. Write the
// polynomial (cfg_we/cfg_wdata) only while the block is idle.
// ----------------------------------------------------------------------------
module crc64_shift_divider (
	input  logic        clk,
	input  logic        arst_n,

	// configuration: polynomial register
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,     // polynomial

	// input transactions
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,       // [7:0] data_byte
	input  logic        s_tuser,       // [0] req_type: 0 data, 1 finalize

	// result transactions
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata        // [63:0] crc_value
);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;  // bit steps through the shared unit
	localparam logic [1:0] ST_EMIT = 2'd2;  // hand CRC to output register

	// step counter holds up to 64 flush steps
	localparam int unsigned CNT_W = 7;

	logic [1:0]           state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 fin_q;     // current run is a finalize flush
	crc64sd_pkg::crc_t    crc_q;
	crc64sd_pkg::crc_t    poly_q;
	crc64sd_pkg::seen_t   seen_q;
	crc64sd_pkg::byte_t   sreg_q;    // byte being divided in, MSB first
	logic                 m_tvalid_q;
	crc64sd_pkg::crc_t    m_tdata_q;

	crc64sd_pkg::step_in_t step_op;
	crc64sd_pkg::crc_t     step_crc;

	logic in_acc;
	logic out_free;
	logic fill_phase;

	assign s_tready   = (state_q == ST_IDLE);
	assign in_acc     = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign fill_phase = (seen_q < crc64sd_pkg::FILL_BYTES);
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;

	// flush steps feed zero message bits
	assign step_op.crc     = crc_q;
	assign step_op.poly    = poly_q;
	assign step_op.msg_bit = fin_q ? 1'b0 : sreg_q[crc64sd_pkg::BYTE_W-1];

	crc64sd_step u_step (
		.op       (step_op),
		.crc_next (step_crc)
	);

	// polynomial register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= crc64sd_pkg::POLY_RESET;
		end else if (cfg_we) begin
			poly_q <= cfg_wdata;
		end
	end

	// sequencer and CRC state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			fin_q   <= 1'b0;
			crc_q   <= '0;
			seen_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser) begin
							// flush 8 zero bits per byte seen (seen <= 8)
							fin_q   <= 1'b1;
							cnt_q   <= {seen_q, 3'b000};
							state_q <= (seen_q == '0) ? ST_EMIT : ST_RUN;
						end else if (fill_phase) begin
							crc_q  <= {crc_q[crc64sd_pkg::CRC_W-9:0], s_tdata};
							seen_q <= seen_q + 1'b1;
						end else begin
							fin_q   <= 1'b0;
							cnt_q   <= CNT_W'(crc64sd_pkg::BYTE_W);
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					crc_q <= step_crc;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= fin_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						crc_q   <= '0;
						seen_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// message byte shift register, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc && !s_tuser) begin
			sreg_q <= s_tdata;
		end else if (state_q == ST_RUN) begin
			sreg_q <= {sreg_q[crc64sd_pkg::BYTE_W-2:0], 1'b0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			m_tdata_q <= crc_q;
		end
	end

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_run_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> cnt_q != '0)
		else $error("bit-step run with empty counter");

	a_seen_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= crc64sd_pkg::FILL_BYTES)
		else $error("byte count above saturation");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free) |=> (crc_q == '0 && seen_q == '0 && m_tvalid_q))
		else $error("finalize did not clear state or post result");

	a_fill_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !s_tuser && fill_phase) |=> seen_q == $past(seen_q) + 1'b1)
		else $error("fill byte not counted");

	a_flush_len: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tuser) |=> (fin_q && cnt_q == {$past(seen_q), 3'b000}))
		else $error("flush length does not match bytes seen");

endmodule

/* tb/crc64_shift_divider_test.sv */
// ----------------------------------------------------------------------------
// crc64_shift_divider_test - self-checking bench for the CRC64 shift divider
// Streams message bytes and finalize transactions through the block, predicts
// each CRC with a bit-level long-division model, and checks every result in
// order. The polynomial is changed between phases, mid-message too.
// ----------------------------------------------------------------------------
module crc64_shift_divider_test;
	timeunit 1ns;
	timeprecision 1ps;

	// one input transaction: data byte or finalize
	typedef struct {
		logic                fin;
		crc64sd_pkg::byte_t  data;
	} crc_req_t;

	localparam int unsigned NUM_PHASES    = 10;
	localparam int unsigned PHASE_ITEMS   = 130;
	localparam int unsigned SETTLE_CYCLES = 30;
	localparam int unsigned DRAIN_CYCLES  = 80;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned MAX_PRINTS    = 100;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [63:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;        // [7:0] data_byte
	logic        s_tuser = 1'b0;      // [0] req_type: 0 data, 1 finalize
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;             // [63:0] crc_value

	crc64_shift_divider dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// CRC model state, mirrors the block's register, count and polynomial
	// ------------------------------------------------------------------
	crc64sd_pkg::crc_t  model_poly = crc64sd_pkg::POLY_RESET;
	crc64sd_pkg::crc_t  model_crc  = '0;
	crc64sd_pkg::seen_t model_seen = '0;

	crc_req_t          pending_reqs[$];   // filled by the sequencer, drained by the driver
	crc64sd_pkg::crc_t expected_crcs[$];  // CRCs owed by the block, oldest first

	int unsigned error_count    = 0;
	int unsigned items_accepted = 0;
	int unsigned crcs_checked   = 0;
	int unsigned poly_writes    = 0;
	int unsigned open_changes   = 0; // polynomial changed inside a message
	int unsigned input_stalls   = 0; // sender blocked while the receiver held off
	int unsigned longest_msg    = 0;
	int unsigned msg_len        = 0;
	bit          calm = 1'b0;        // no gaps on either side
	bit          hold_off = 1'b0;    // receiver held off for pressure

	// one MSB-first division of a byte into the register
	function automatic crc64sd_pkg::crc_t divide_in(crc64sd_pkg::crc_t r,
			crc64sd_pkg::byte_t b, crc64sd_pkg::crc_t p);
		logic top;
		for (int k = crc64sd_pkg::BYTE_W - 1; k >= 0; k--) begin
			top = r[crc64sd_pkg::CRC_W-1];
			r = {r[crc64sd_pkg::CRC_W-2:0], b[k]};
			if (top)
				r ^= p;
		end
		return r;
	endfunction

	// apply one accepted transaction; a finalize owes one CRC
	task automatic crc_model_step(input crc_req_t req);
		if (!req.fin) begin
			// the first eight bytes load straight in, the rest are divided
			if (model_seen < crc64sd_pkg::FILL_BYTES) begin
				model_crc  = {model_crc[crc64sd_pkg::CRC_W-crc64sd_pkg::BYTE_W-1:0],
					req.data};
				model_seen = model_seen + 1'b1;
			end else begin
				model_crc = divide_in(model_crc, req.data, model_poly);
			end
			msg_len++;
		end else begin
			// augment with as many zero bytes as arrived, at most eight
			for (int k = 0; k < int'(model_seen); k++)
				model_crc = divide_in(model_crc, 8'h00, model_poly);
			expected_crcs.push_back(model_crc);
			model_crc  = '0;
			model_seen = '0;
			if (msg_len > longest_msg)
				longest_msg = msg_len;
			msg_len = 0;
		end
	endtask

	task automatic report_mismatch(input string what, input crc64sd_pkg::crc_t got,
			input crc64sd_pkg::crc_t want);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("[%0t] MISMATCH %s: got %016h expected %016h", $realtime, what, got, want);
	endtask

	// gap length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents queued transactions, holds each until accepted
	// ------------------------------------------------------------------
	int unsigned send_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		crc_req_t cur;
		crc_req_t nxt;
		logic     valid_next;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
			send_gap = 0;
		end else begin
			valid_next = s_tvalid;
			if (s_tvalid && !s_tready && hold_off)
				input_stalls++;
			if (s_tvalid && s_tready) begin
				cur.fin  = s_tuser;
				cur.data = s_tdata;
				crc_model_step(cur);
				items_accepted++;
				valid_next = 1'b0;
			end
			if (!valid_next) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_reqs.size() != 0) begin
					nxt = pending_reqs.pop_front();
					s_tdata  <= nxt.data;
					s_tuser  <= nxt.fin;
					valid_next = 1'b1;
					send_gap = pick_gap();
				end
			end
			s_tvalid <= valid_next;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: random back-pressure, in-order CRC check
	// ------------------------------------------------------------------
	int unsigned ready_stall = 0;

	always @(posedge clk or negedge arst_n) begin
		crc64sd_pkg::crc_t want;
		logic ready_next;
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_crcs.size() == 0) begin
					report_mismatch("unexpected crc_value", m_tdata, '0);
				end else begin
					want = expected_crcs.pop_front();
					if (m_tdata !== want)
						report_mismatch("crc_value", m_tdata, want);
					crcs_checked++;
				end
			end
			if (hold_off) begin
				ready_next = 1'b0;
			end else if (ready_stall > 0) begin
				ready_stall--;
				ready_next = 1'b0;
			end else begin
				ready_next = 1'b1;
				if ($urandom_range(0, 3) == 0)
					ready_stall = pick_gap();
			end
			m_tready <= ready_next;
		end
	end

	// long receiver hold-off once results are flowing; the output register
	// fills and the next finalize stalls the input
	initial begin
		do @(negedge clk); while (crcs_checked < 30);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off = 1'b0;
	end

	// ------------------------------------------------------------------
	// Sequencer helpers
	// ------------------------------------------------------------------
	function automatic crc64sd_pkg::byte_t pick_byte();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return crc64sd_pkg::byte_t'($urandom_range(0, 255));
	endfunction

	task automatic queue_data(input crc64sd_pkg::byte_t b);
		crc_req_t req;
		req.fin  = 1'b0;
		req.data = b;
		pending_reqs.push_back(req);
	endtask

	// finalize carries a random byte that the block must ignore
	task automatic queue_finalize();
		crc_req_t req;
		req.fin  = 1'b1;
		req.data = crc64sd_pkg::byte_t'($urandom_range(0, 255));
		pending_reqs.push_back(req);
	endtask

	// wait until all queued transactions are accepted and all CRCs are in
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || s_tvalid || expected_crcs.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_poly(input crc64sd_pkg::crc_t p);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_we    <= 1'b0;
		model_poly = p;
		poly_writes++;
		if (model_seen != 0)
			open_changes++;
	endtask

	// random messages, half of them past the eight-byte load so division runs;
	// optionally leaves the last message open across the next poly write
	task automatic queue_phase(input int unsigned n_items, input bit leave_open);
		int unsigned count;
		int unsigned len;
		int unsigned r;
		count = 0;
		while (count < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				len = 0;
			else if (r < 40)
				len = $urandom_range(1, 7);
			else if (r < 50)
				len = 8;
			else if (r < 95)
				len = $urandom_range(9, 24);
			else
				len = $urandom_range(40, 70);
			repeat (len) queue_data(pick_byte());
			queue_finalize();
			count += len + 1;
		end
		if (leave_open)
			repeat ($urandom_range(3, 12)) queue_data(pick_byte());
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	crc64sd_pkg::crc_t poly_set[NUM_PHASES];

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset polynomial: empty message right after reset
		queue_finalize();
		// one zero byte
		queue_data(8'h00);
		queue_finalize();
		// exactly eight bytes: loaded, then a full eight-byte flush
		repeat (8) queue_data(8'hFF);
		queue_finalize();
		// nine bytes: the ninth is the first divided one
		queue_data(8'h80); queue_data(8'h01); queue_data(8'h00); queue_data(8'hFF);
		queue_data(8'h55); queue_data(8'hAA); queue_data(8'h7F); queue_data(8'hFE);
		queue_data(8'hFF);
		queue_finalize();
		// back-to-back empty messages
		queue_finalize();
		queue_finalize();
		wait_idle();

		poly_set[0] = '0;
		poly_set[1] = '1;
		poly_set[2] = 64'h0000_0000_0000_0001;
		poly_set[3] = 64'h8000_0000_0000_0000;
		poly_set[4] = {$urandom, $urandom};
		poly_set[5] = 64'h42F0_E1EB_A9EA_3693 ^ 64'h1;
		poly_set[6] = {$urandom, $urandom};
		poly_set[7] = 64'h5555_5555_AAAA_AAAA;
		poly_set[8] = {$urandom, $urandom};
		poly_set[9] = crc64sd_pkg::POLY_RESET;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_poly(poly_set[ph]);
			calm = (ph % 4 == 3);
			// odd phases but the last hand an open message to the next polynomial
			queue_phase(PHASE_ITEMS, (ph % 2 == 1) && (ph != NUM_PHASES - 1));
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		while (expected_crcs.size() != 0) begin
			report_mismatch("missing crc_value", '0, expected_crcs.pop_front());
		end

		$display("Covered %0d transactions, %0d CRCs checked, messages up to %0d bytes.",
			items_accepted, crcs_checked, longest_msg);
		$display("Polynomial written %0d times (%0d inside a message); %0d input stall cycles.",
			poly_writes, open_changes, input_stalls);
		if (error_count == 0) begin
			$display("crc64_shift_divider_test: clean");
		end else begin
			$display("crc64_shift_divider_test: errors");
		end
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#10_000_000;
		$display("Timeout with %0d CRCs still owed.", expected_crcs.size());
		$display("crc64_shift_divider_test: errors");
		$finish;
	end

endmodule
